// ===== sv/btnf_pkg.sv =====
// Shared types and constants for the boundary-tag next-fit heap core.
package btnf_pkg;

  // Widths and defaults
  localparam int SIZE_W         = 12;
  localparam int UNIT_SHIFT     = 4;     // 16-byte units
  localparam int HEAP_UNITS_DEF = 4096;
  localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = 12'd4094;

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // One boundary tag: block before and block after
  typedef struct packed {
    logic [SIZE_W-1:0] ps;   // prev size
    logic              pu;   // prev used
    logic [SIZE_W-1:0] ns;   // next size
    logic              nu;   // next used
  } tag_t;

  // Command to the index unit: load acc with a + b + ci
  typedef struct packed {
    logic              load;
    logic              ci;
    logic signed [13:0] b;
  } idx_cmd_t;

  // Usable size after limiting to the store
  function automatic logic [SIZE_W-1:0] clamp_units(input logic [SIZE_W-1:0] v,
                                                    input int units);
    logic [SIZE_W-1:0] r;
    r = v;
    if (int'(v) > units - 2) r = SIZE_W'(units - 2);
    return r;
  endfunction

endpackage

// ===== sv/btnf_idx_unit.sv =====
// Shared index adder: loads a sum, then folds it into the store range.
module btnf_idx_unit #(
  parameter int HEAP_UNITS = btnf_pkg::HEAP_UNITS_DEF,
  parameter int IW = $clog2(HEAP_UNITS),
  parameter int AW = ((IW > 12) ? IW : 12) + 3
) (
  input  logic                clk,
  input  btnf_pkg::idx_cmd_t  cmd,
  input  logic [IW-1:0]       a,
  output logic [AW-1:0]       acc,
  output logic                in_range
);
  import btnf_pkg::*;

  localparam logic [AW-1:0] HSZ = AW'(HEAP_UNITS);

  logic          neg;
  logic          high;
  logic [AW-1:0] op1;
  logic [AW-1:0] op2;
  logic [AW-1:0] sum;

  assign neg      = acc[AW-1];
  assign high     = !neg && (acc >= HSZ);
  assign in_range = !neg && !high;

  // one adder: either the loaded sum or a +/- heap size fold step
  always_comb begin
    if (cmd.load) begin
      op1 = AW'(a);
      op2 = {{(AW-14){cmd.b[13]}}, cmd.b};
    end else begin
      op1 = acc;
      op2 = neg ? HSZ : (high ? (~HSZ + AW'(1)) : '0);
    end
    sum = op1 + op2 + AW'(cmd.load & cmd.ci);
  end

  always_ff @(posedge clk) begin
    acc <= sum;
  end

endmodule

// ===== sv/boundary_tag_next_fit_heap_core.sv =====
// Boundary-tag heap manager with next-fit search over a tag store.
//
// Channels: one input beat (func, req_bytes, free_addr) gives exactly one
// result beat (status, block_addr). A config beat on cfg_* writes
// heap_units and rebuilds an empty heap (two tag writes, then ready).
// Reset does the same with 4094 units and clears the search cursor.
//
// Timing: the block takes one item at a time; in_ready is low until the
// item's result is in the output register. An allocate visits tags on the
// search walk, each visit being one store read plus an index add and range
// fold through the shared index unit, and then does the split and tag
// updates. A free checks both tags and clears the used flags, plus a merge
// for each free neighbor. Each index fold adds or removes one multiple of
// the store depth per step until the index is in range.
// The store has one registered read port and one write port.
//
// A stalled receiver holds the result in the output register; the next
// input beat may be accepted meanwhile and runs until its result needs
// that register. Config beats are taken only while idle.
module boundary_tag_next_fit_heap_core #(
  parameter int HEAP_UNITS = btnf_pkg::HEAP_UNITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] heap_units,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] req_bytes,
  input  logic [11:0] free_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [11:0] block_addr
);
  import btnf_pkg::*;

  localparam int IW        = $clog2(HEAP_UNITS);
  localparam int CW        = (IW > 12) ? IW : 12;
  localparam int AW        = CW + 3;
  localparam int HOP_LIMIT = 2 * HEAP_UNITS + 4;
  localparam int HW        = $clog2(HOP_LIMIT + 2);

  // sequencer states
  localparam logic [4:0] S_INIT0  = 5'd0;
  localparam logic [4:0] S_INIT1  = 5'd1;
  localparam logic [4:0] S_IDLE   = 5'd2;
  localparam logic [4:0] S_A_RD   = 5'd3;
  localparam logic [4:0] S_A_RD0  = 5'd4;
  localparam logic [4:0] S_A_EV   = 5'd5;
  localparam logic [4:0] S_A_NEXT = 5'd6;
  localparam logic [4:0] S_A_BACK = 5'd7;
  localparam logic [4:0] S_A_MID  = 5'd8;
  localparam logic [4:0] S_A_ADDR = 5'd9;
  localparam logic [4:0] S_A_NEW  = 5'd10;
  localparam logic [4:0] S_F_RH   = 5'd11;
  localparam logic [4:0] S_F_H    = 5'd12;
  localparam logic [4:0] S_F_T    = 5'd13;
  localparam logic [4:0] S_F_W2   = 5'd14;
  localparam logic [4:0] S_F_RT   = 5'd15;
  localparam logic [4:0] S_F_CT   = 5'd16;
  localparam logic [4:0] S_M_RD   = 5'd17;
  localparam logic [4:0] S_M_EV   = 5'd18;
  localparam logic [4:0] S_M_HI   = 5'd19;
  localparam logic [4:0] S_M_LO   = 5'd20;
  localparam logic [4:0] S_RMW_RD = 5'd21;
  localparam logic [4:0] S_RMW_WR = 5'd22;
  localparam logic [4:0] S_WRAP   = 5'd23;
  localparam logic [4:0] S_DONE   = 5'd24;

  // read-modify-write operations on one tag
  localparam logic [2:0] OP_A_CUR_NS   = 3'd0;
  localparam logic [2:0] OP_A_MID      = 3'd1;
  localparam logic [2:0] OP_A_BACK     = 3'd2;
  localparam logic [2:0] OP_A_MID_USED = 3'd3;
  localparam logic [2:0] OP_A_CUR_NU   = 3'd4;
  localparam logic [2:0] OP_A_NEW_PU   = 3'd5;
  localparam logic [2:0] OP_M_LO       = 3'd6;
  localparam logic [2:0] OP_M_HI       = 3'd7;

  // tag store
  tag_t mem [HEAP_UNITS];
  tag_t rdata;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  tag_t          wr_data;

  // sequencer registers
  logic [4:0]    state;
  logic [4:0]    ret;
  logic [2:0]    op;
  logic [IW-1:0] op_addr;
  logic [IW-1:0] cur;
  logic [IW-1:0] mid;
  logic [IW-1:0] back;
  logic [IW-1:0] hi;
  logic [IW-1:0] center;
  logic [IW-1:0] tail;
  logic [11:0]   head;
  logic [11:0]   heap_size;
  logic [11:0]   cursor;
  logic [12:0]   req;
  logic [11:0]   rest;
  logic [11:0]   sz;
  logic [11:0]   blk;
  logic [HW-1:0] hops;
  logic          wrapped;
  logic          zchk;
  logic          split;
  logic          mphase;
  logic          cmatch;
  tag_t          htag;
  tag_t          ttag;
  tag_t          ctag;
  logic [1:0]    res_status;
  logic [11:0]   res_addr;

  // index unit
  idx_cmd_t      cmd;
  logic [IW-1:0] unit_a;
  logic [AW-1:0] acc;
  logic          idx_ok;

  // decode helpers
  logic [16:0] bytes_up;
  logic [12:0] req_in;
  logic        a_zero;
  logic        a_fit;
  logic        a_split;
  logic [12:0] f_end;
  logic        f_good;
  logic        hop_over;
  logic        out_free;

  assign bytes_up = {1'b0, req_bytes} + 17'd15;
  assign req_in   = (bytes_up[16:UNIT_SHIFT] == 13'd0) ? 13'd1 : bytes_up[16:UNIT_SHIFT];
  assign a_zero   = !zchk && (rdata.ns == 12'd0);
  assign a_fit    = !rdata.nu && ({1'b0, rdata.ns} >= req);
  assign a_split  = {2'b00, rdata.ns} > ({1'b0, req} + 14'd1);
  assign f_end    = {1'b0, head} + {1'b0, rdata.ns};
  assign f_good   = htag.nu && rdata.pu && (htag.ns == rdata.ps);
  assign hop_over = hops > HW'(HOP_LIMIT);
  assign out_free = !out_valid || out_ready;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  btnf_idx_unit #(
    .HEAP_UNITS (HEAP_UNITS),
    .IW         (IW),
    .AW         (AW)
  ) u_idx (
    .clk      (clk),
    .cmd      (cmd),
    .a        (unit_a),
    .acc      (acc),
    .in_range (idx_ok)
  );

  // store port: registered read, one write
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // store access and index unit commands per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = op_addr;
    wr_en   = 1'b0;
    wr_addr = op_addr;
    wr_data = rdata;
    cmd     = '0;
    unit_a  = cur;
    unique case (state)
      S_INIT0: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '{ps: 12'd0, pu: 1'b0, ns: heap_size, nu: 1'b0};
      end
      S_INIT1: begin
        wr_en   = 1'b1;
        wr_addr = IW'({1'b0, heap_size} + 13'd1);
        wr_data = '{ps: heap_size, pu: 1'b0, ns: 12'd0, nu: 1'b0};
      end
      S_A_RD: begin
        rd_en   = !hop_over;
        rd_addr = cur;
      end
      S_A_RD0: begin
        rd_en   = 1'b1;
        rd_addr = cur;
      end
      S_A_EV: begin
        // next tag, or first data unit when no split is needed
        cmd.load = !a_zero;
        cmd.ci   = 1'b1;
        cmd.b    = (a_fit && !a_split) ? 14'sd0 : $signed({2'b00, rdata.ns});
      end
      S_A_BACK: begin
        cmd.load = 1'b1;
        cmd.ci   = 1'b1;
        cmd.b    = $signed({1'b0, req});
      end
      S_A_MID: begin
        cmd.load = 1'b1;
        cmd.ci   = 1'b1;
        cmd.b    = 14'sd0;
      end
      S_F_RH: begin
        rd_en   = 1'b1;
        rd_addr = IW'(head);
      end
      S_F_H: begin
        rd_en   = 1'b1;
        rd_addr = IW'(f_end + 13'd1);
      end
      S_F_T: begin
        wr_en   = f_good;
        wr_addr = IW'(head);
        wr_data = htag;
        wr_data.nu = 1'b0;
      end
      S_F_W2: begin
        wr_en   = 1'b1;
        wr_addr = tail;
        wr_data = ttag;
        wr_data.pu = 1'b0;
      end
      S_F_RT: begin
        rd_en   = 1'b1;
        rd_addr = tail;
      end
      S_M_RD: begin
        rd_en   = 1'b1;
        rd_addr = center;
      end
      S_M_EV: begin
        unit_a   = center;
        cmd.load = 1'b1;
        cmd.ci   = 1'b1;
        cmd.b    = $signed({2'b00, rdata.ns});
      end
      S_M_HI: begin
        // center - 1 - prev size
        unit_a   = center;
        cmd.load = 1'b1;
        cmd.ci   = 1'b0;
        cmd.b    = $signed(~{2'b00, ctag.ps});
      end
      S_RMW_RD: begin
        rd_en = 1'b1;
      end
      S_RMW_WR: begin
        wr_en = 1'b1;
        case (op)
          OP_A_CUR_NS: wr_data.ns = req[11:0];
          OP_A_MID: begin
            wr_data.ps = req[11:0];
            wr_data.ns = rest;
          end
          OP_A_BACK: wr_data.ps = rest;
          OP_A_MID_USED: begin
            wr_data.nu = 1'b0;
            wr_data.pu = 1'b0;
          end
          OP_A_CUR_NU: begin
            wr_data.nu = 1'b1;
            cmd.load   = 1'b1;
            cmd.ci     = 1'b1;
            cmd.b      = $signed({2'b00, rdata.ns});
          end
          OP_A_NEW_PU: wr_data.pu = 1'b1;
          OP_M_LO:     wr_data.ns = sz;
          OP_M_HI:     wr_data.ps = sz;
          default:     wr_en = 1'b0;
        endcase
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT0;
      heap_size <= clamp_units(HEAP_SIZE_RST, HEAP_UNITS);
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register
      if (state == S_DONE && out_free) begin
        out_valid  <= 1'b1;
        status     <= res_status;
        block_addr <= res_addr;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_INIT0: state <= S_INIT1;
        S_INIT1: state <= S_IDLE;
        S_IDLE: begin
          if (cfg_valid) begin
            heap_size <= clamp_units(heap_units, HEAP_UNITS);
            cursor    <= '0;
            state     <= S_INIT0;
          end else if (in_valid) begin
            if (func == FUNC_ALLOC) begin
              cur     <= IW'(cursor);
              hops    <= '0;
              wrapped <= 1'b0;
              req     <= req_in;
              state   <= S_A_RD;
            end else if (free_addr == 12'd0 || free_addr > heap_size) begin
              res_status <= ST_BAD_FREE;
              res_addr   <= '0;
              state      <= S_DONE;
            end else begin
              head  <= free_addr - 12'd1;
              state <= S_F_RH;
            end
          end
        end

        // next-fit walk
        S_A_RD: begin
          if (hop_over) begin
            res_status <= ST_NO_MEM;
            res_addr   <= '0;
            state      <= S_DONE;
          end else begin
            hops  <= hops + HW'(1);
            zchk  <= 1'b0;
            state <= S_A_EV;
          end
        end
        S_A_RD0: begin
          zchk  <= 1'b1;
          state <= S_A_EV;
        end
        S_A_EV: begin
          if (a_zero) begin
            // top tag: wrap to base once
            if (wrapped) begin
              res_status <= ST_NO_MEM;
              res_addr   <= '0;
              state      <= S_DONE;
            end else begin
              cur     <= '0;
              wrapped <= 1'b1;
              state   <= S_A_RD0;
            end
          end else if (a_fit) begin
            split <= a_split;
            rest  <= rdata.ns - req[11:0] - 12'd1;
            ret   <= a_split ? S_A_BACK : S_A_ADDR;
            state <= S_WRAP;
          end else begin
            ret   <= S_A_NEXT;
            state <= S_WRAP;
          end
        end
        S_A_NEXT: begin
          cur   <= IW'(acc);
          state <= S_A_RD;
        end
        S_A_BACK: begin
          back  <= IW'(acc);
          ret   <= S_A_MID;
          state <= S_WRAP;
        end
        S_A_MID: begin
          mid   <= IW'(acc);
          ret   <= S_A_ADDR;
          state <= S_WRAP;
        end
        S_A_ADDR: begin
          blk     <= 12'(acc);
          op      <= split ? OP_A_CUR_NS : OP_A_CUR_NU;
          op_addr <= cur;
          state   <= S_RMW_RD;
        end
        S_A_NEW: begin
          op      <= OP_A_NEW_PU;
          op_addr <= IW'(acc);
          state   <= S_RMW_RD;
        end

        // free: check both tags, clear used flags
        S_F_RH: state <= S_F_H;
        S_F_H: begin
          htag <= rdata;
          tail <= IW'(f_end + 13'd1);
          if (f_end > {1'b0, heap_size}) begin
            res_status <= ST_BAD_FREE;
            res_addr   <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_F_T;
          end
        end
        S_F_T: begin
          ttag <= rdata;
          if (!f_good) begin
            res_status <= ST_BAD_FREE;
            res_addr   <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_F_W2;
          end
        end
        S_F_W2: begin
          if (!htag.pu && htag.ps != 12'd0) begin
            center <= IW'(head);
            mphase <= 1'b0;
            state  <= S_M_RD;
          end else begin
            state <= S_F_RT;
          end
        end
        S_F_RT: state <= S_F_CT;
        S_F_CT: begin
          if (!rdata.nu && rdata.ns != 12'd0) begin
            center <= tail;
            mphase <= 1'b1;
            state  <= S_M_EV;
          end else begin
            res_status <= ST_OK;
            res_addr   <= '0;
            state      <= S_DONE;
          end
        end

        // merge around one tag
        S_M_RD: state <= S_M_EV;
        S_M_EV: begin
          ctag   <= rdata;
          sz     <= rdata.ns + rdata.ps + 12'd1;
          cmatch <= (CW'(cursor) == CW'(center));
          ret    <= S_M_HI;
          state  <= S_WRAP;
        end
        S_M_HI: begin
          hi <= IW'(acc);
          if (cmatch) cursor <= 12'(acc);
          ret   <= S_M_LO;
          state <= S_WRAP;
        end
        S_M_LO: begin
          op      <= OP_M_LO;
          op_addr <= IW'(acc);
          state   <= S_RMW_RD;
        end

        // tag read-modify-write chain
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          case (op)
            OP_A_CUR_NS: begin
              op      <= OP_A_MID;
              op_addr <= mid;
              state   <= S_RMW_RD;
            end
            OP_A_MID: begin
              op      <= OP_A_BACK;
              op_addr <= back;
              state   <= S_RMW_RD;
            end
            OP_A_BACK: begin
              op      <= OP_A_MID_USED;
              op_addr <= mid;
              state   <= S_RMW_RD;
            end
            OP_A_MID_USED: begin
              op      <= OP_A_CUR_NU;
              op_addr <= cur;
              state   <= S_RMW_RD;
            end
            OP_A_CUR_NU: begin
              ret   <= S_A_NEW;
              state <= S_WRAP;
            end
            OP_A_NEW_PU: begin
              cursor     <= 12'(op_addr);
              res_status <= ST_OK;
              res_addr   <= blk;
              state      <= S_DONE;
            end
            OP_M_LO: begin
              op      <= OP_M_HI;
              op_addr <= hi;
              state   <= S_RMW_RD;
            end
            default: begin
              if (mphase) begin
                res_status <= ST_OK;
                res_addr   <= '0;
                state      <= S_DONE;
              end else begin
                state <= S_F_RT;
              end
            end
          endcase
        end

        // fold index into range
        S_WRAP: begin
          if (idx_ok) state <= ret;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
